[sv/sasc_pkg.sv]
// Shared constants and types for the altitude slab clipper.
package sasc_pkg;

    localparam int CFG_IDX_BITS = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SLAB_BOTTOM = 2'd0,
        CFG_SLAB_HEIGHT = 2'd1
    } cfg_idx_t;

    // per-item clip decisions, decode stage to output select
    typedef struct packed {
        logic hit;
        logic mv_from;
        logic mv_to;
    } clip_flags_t;

endpackage

[sv/sasc_decode.sv]
// Decode stage: slab classification, boundary distances and lane operands.
module sasc_decode
    import sasc_pkg::*;
#(
    parameter int COORD_BITS = 32
)
(
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [COORD_BITS-1:0] slab_bottom,
    input  logic        [COORD_BITS-2:0] slab_height,
    input  logic signed [COORD_BITS-1:0] from_x,
    input  logic signed [COORD_BITS-1:0] from_y,
    input  logic signed [COORD_BITS-1:0] from_z,
    input  logic signed [COORD_BITS-1:0] to_x,
    input  logic signed [COORD_BITS-1:0] to_y,
    input  logic signed [COORD_BITS-1:0] to_z,
    output clip_flags_t                  flags,
    output logic signed [COORD_BITS-1:0] clip_fy,
    output logic signed [COORD_BITS-1:0] clip_ty,
    output logic signed [COORD_BITS-1:0] orig_fx,
    output logic signed [COORD_BITS-1:0] orig_fz,
    output logic signed [COORD_BITS-1:0] orig_tx,
    output logic signed [COORD_BITS-1:0] orig_tz,
    output logic signed [COORD_BITS-1:0] base_tx,
    output logic signed [COORD_BITS-1:0] base_tz,
    output logic        [COORD_BITS-1:0] mag_dx,
    output logic        [COORD_BITS-1:0] mag_dz,
    output logic        [COORD_BITS-1:0] mag_dy,
    output logic        [COORD_BITS-1:0] mag_nf,
    output logic        [COORD_BITS-1:0] mag_nt,
    output logic                         neg_fx,
    output logic                         neg_fz,
    output logic                         neg_tx,
    output logic                         neg_tz
);

    localparam int W = COORD_BITS + 1;

    logic signed [W-1:0] b, t, fy, ty, dx, dy, dz, nf, nt;
    logic above, below, to_base_from;
    clip_flags_t flags_next;
    logic signed [W-1:0] cfy_next, cty_next;

    clip_flags_t                  flags_reg;
    logic signed [COORD_BITS-1:0] cfy_reg, cty_reg, fx_reg, fz_reg, tx_reg, tz_reg;
    logic signed [COORD_BITS-1:0] btx_reg, btz_reg;
    logic        [COORD_BITS-1:0] mdx_reg, mdz_reg, mdy_reg, mnf_reg, mnt_reg;
    logic                         nfx_reg, nfz_reg, ntx_reg, ntz_reg;

    function automatic logic [COORD_BITS-1:0] mag_of(input logic signed [W-1:0] v);
        logic signed [W-1:0] a;
        a = v[W-1] ? -v : v;
        return a[COORD_BITS-1:0];
    endfunction

    always_comb
    begin
        b  = W'(slab_bottom);
        t  = b + $signed({2'b00, slab_height});
        fy = W'(from_y);
        ty = W'(to_y);
        dx = W'(to_x) - W'(from_x);
        dy = ty - fy;
        dz = W'(to_z) - W'(from_z);
        above = fy > t;
        below = fy < b;
        flags_next = '{hit: 1'b1, mv_from: 1'b0, mv_to: 1'b0};
        nf = t - fy;
        nt = b - ty;
        to_base_from = 1'b0;
        cfy_next = fy;
        cty_next = ty;
        if (above)
        begin
            flags_next.hit     = ty < t;
            flags_next.mv_from = ty < t;
            flags_next.mv_to   = ty < b;
            nf = t - fy;
            nt = b - ty;
            if (flags_next.mv_from)
                cfy_next = t;
            if (flags_next.mv_to)
                cty_next = b;
        end
        else if (below)
        begin
            flags_next.hit     = ty > b;
            flags_next.mv_from = ty > b;
            flags_next.mv_to   = ty >= t && ty > b;
            nf = b - fy;
            nt = t - ty;
            if (flags_next.mv_from)
                cfy_next = b;
            if (flags_next.mv_to)
                cty_next = t;
        end
        else
        begin
            // start inside: end cut from the start point
            to_base_from = 1'b1;
            if (ty > t)
            begin
                flags_next.mv_to = 1'b1;
                nt = t - fy;
                cty_next = t;
            end
            else if (ty < b)
            begin
                flags_next.mv_to = 1'b1;
                nt = b - fy;
                cty_next = b;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flags_reg <= flags_next;
            cfy_reg   <= cfy_next[COORD_BITS-1:0];
            cty_reg   <= cty_next[COORD_BITS-1:0];
            fx_reg    <= from_x;
            fz_reg    <= from_z;
            tx_reg    <= to_x;
            tz_reg    <= to_z;
            btx_reg   <= to_base_from ? from_x : to_x;
            btz_reg   <= to_base_from ? from_z : to_z;
            mdx_reg   <= mag_of(dx);
            mdz_reg   <= mag_of(dz);
            mdy_reg   <= mag_of(dy);
            mnf_reg   <= mag_of(nf);
            mnt_reg   <= mag_of(nt);
            nfx_reg   <= dx[W-1] ^ nf[W-1] ^ dy[W-1];
            nfz_reg   <= dz[W-1] ^ nf[W-1] ^ dy[W-1];
            ntx_reg   <= dx[W-1] ^ nt[W-1] ^ dy[W-1];
            ntz_reg   <= dz[W-1] ^ nt[W-1] ^ dy[W-1];
        end
    end

    assign flags   = flags_reg;
    assign clip_fy = cfy_reg;
    assign clip_ty = cty_reg;
    assign orig_fx = fx_reg;
    assign orig_fz = fz_reg;
    assign orig_tx = tx_reg;
    assign orig_tz = tz_reg;
    assign base_tx = btx_reg;
    assign base_tz = btz_reg;
    assign mag_dx  = mdx_reg;
    assign mag_dz  = mdz_reg;
    assign mag_dy  = mdy_reg;
    assign mag_nf  = mnf_reg;
    assign mag_nt  = mnt_reg;
    assign neg_fx  = nfx_reg;
    assign neg_fz  = nfz_reg;
    assign neg_tx  = ntx_reg;
    assign neg_tz  = ntz_reg;

endmodule

[sv/sasc_lane.sv]
// One interpolation lane: multiply, restoring divide one bit a stage, offset.
module sasc_lane
    import sasc_pkg::*;
#(
    parameter int COORD_BITS = 32
)
(
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [COORD_BITS-1:0] base,
    input  logic        [COORD_BITS-1:0] mag_a,
    input  logic        [COORD_BITS-1:0] mag_b,
    input  logic        [COORD_BITS-1:0] mag_c,
    input  logic                         neg,
    output logic signed [COORD_BITS-1:0] result
);

    localparam int C = COORD_BITS;

    logic        [2*C-1:0] prod_reg;
    logic        [C-1:0]   c0_reg;
    logic signed [C-1:0]   base0_reg;
    logic                  neg0_reg;

    logic        [C:0]     r_reg    [C];
    logic        [C-1:0]   lo_reg   [C];
    logic        [C-1:0]   q_reg    [C];
    logic        [C-1:0]   c_reg    [C];
    logic signed [C-1:0]   base_reg [C];
    logic                  neg_reg  [C];

    logic signed [C-1:0]   result_reg;
    logic signed [C:0]     sum;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= mag_a * mag_b;
            c0_reg    <= mag_c;
            base0_reg <= base;
            neg0_reg  <= neg;
        end
    end

    // quotient fits C bits since |n| <= |dy|, so the high half starts the remainder
    for (genvar k = 0; k < C; k++)
    begin : g_div
        logic [C:0]   r_prev, r2, r_next;
        logic [C-1:0] lo_prev, q_prev, c_prev;
        logic signed [C-1:0] base_prev;
        logic         neg_prev, ge;

        if (k == 0)
        begin : g_first
            assign r_prev    = {1'b0, prod_reg[2*C-1:C]};
            assign lo_prev   = prod_reg[C-1:0];
            assign q_prev    = '0;
            assign c_prev    = c0_reg;
            assign base_prev = base0_reg;
            assign neg_prev  = neg0_reg;
        end
        else
        begin : g_rest
            assign r_prev    = r_reg[k-1];
            assign lo_prev   = lo_reg[k-1];
            assign q_prev    = q_reg[k-1];
            assign c_prev    = c_reg[k-1];
            assign base_prev = base_reg[k-1];
            assign neg_prev  = neg_reg[k-1];
        end

        always_comb
        begin
            r2     = {r_prev[C-1:0], lo_prev[C-1]};
            ge     = r2 >= {1'b0, c_prev};
            r_next = ge ? r2 - {1'b0, c_prev} : r2;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k]    <= r_next;
                lo_reg[k]   <= {lo_prev[C-2:0], 1'b0};
                q_reg[k]    <= {q_prev[C-2:0], ge};
                c_reg[k]    <= c_prev;
                base_reg[k] <= base_prev;
                neg_reg[k]  <= neg_prev;
            end
        end
    end

    always_comb
    begin
        if (neg_reg[C-1])
            sum = (C+1)'(base_reg[C-1]) - $signed({1'b0, q_reg[C-1]});
        else
            sum = (C+1)'(base_reg[C-1]) + $signed({1'b0, q_reg[C-1]});
    end

    always_ff @(posedge clk)
    begin
        if (en)
            result_reg <= sum[C-1:0];
    end

    assign result = result_reg;

endmodule

[sv/segment_altitude_slab_clip.sv]
// Top level of the altitude slab clipper: config registers, pipeline control, output select.
//
//  channel  direction  handshake          payload
//  in       sink       in_valid/in_stall  from_x/y/z, to_x/y/z
//  out      source     out_valid/out_stall touches_slab, clip_from_x/y/z, clip_to_x/y/z
//  cfg      sink       cfg_valid/cfg_ready cfg_index, cfg_data
//
// One transaction per cycle while out_stall does not hold the pipeline; a
// decode stage and a multiply stage feed the divider stages (one quotient bit each).
// Reset clears the valid bits and both slab registers.
// A stalled result freezes the whole pipeline; in_stall follows from it.
module segment_altitude_slab_clip
    import sasc_pkg::*;
#(
    parameter int COORD_BITS = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] from_x,
    input  logic signed [COORD_BITS-1:0] from_y,
    input  logic signed [COORD_BITS-1:0] from_z,
    input  logic signed [COORD_BITS-1:0] to_x,
    input  logic signed [COORD_BITS-1:0] to_y,
    input  logic signed [COORD_BITS-1:0] to_z,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         touches_slab,
    output logic signed [COORD_BITS-1:0] clip_from_x,
    output logic signed [COORD_BITS-1:0] clip_from_y,
    output logic signed [COORD_BITS-1:0] clip_from_z,
    output logic signed [COORD_BITS-1:0] clip_to_x,
    output logic signed [COORD_BITS-1:0] clip_to_y,
    output logic signed [COORD_BITS-1:0] clip_to_z,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [COORD_BITS-1:0]        cfg_data
);

    localparam int C = COORD_BITS;
    localparam int L = C + 2;   // lane depth after decode

    logic signed [C-1:0] slab_bottom_reg;
    logic        [C-2:0] slab_height_reg;

    logic adv;

    clip_flags_t         d_flags;
    logic signed [C-1:0] d_cfy, d_cty, d_fx, d_fz, d_tx, d_tz, d_btx, d_btz;
    logic        [C-1:0] d_mdx, d_mdz, d_mdy, d_mnf, d_mnt;
    logic                d_nfx, d_nfz, d_ntx, d_ntz;
    logic signed [C-1:0] l_fx, l_fz, l_tx, l_tz;

    logic                dec_vld_reg;
    logic                vld_reg [L];
    clip_flags_t         flg_reg [L];
    logic signed [C-1:0] cfy_reg [L];
    logic signed [C-1:0] cty_reg [L];
    logic signed [C-1:0] fx_reg  [L];
    logic signed [C-1:0] fz_reg  [L];
    logic signed [C-1:0] tx_reg  [L];
    logic signed [C-1:0] tz_reg  [L];

    // configuration: always ready, unknown indexes dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slab_bottom_reg <= '0;
            slab_height_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SLAB_BOTTOM: slab_bottom_reg <= cfg_data;
                CFG_SLAB_HEIGHT: slab_height_reg <= cfg_data[C-2:0];
                default: ;
            endcase
        end
    end

    // whole pipe moves unless a finished transaction is held at the output
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    sasc_decode #(.COORD_BITS(C)) u_decode (
        .clk         (clk),
        .en          (adv),
        .slab_bottom (slab_bottom_reg),
        .slab_height (slab_height_reg),
        .from_x      (from_x),
        .from_y      (from_y),
        .from_z      (from_z),
        .to_x        (to_x),
        .to_y        (to_y),
        .to_z        (to_z),
        .flags       (d_flags),
        .clip_fy     (d_cfy),
        .clip_ty     (d_cty),
        .orig_fx     (d_fx),
        .orig_fz     (d_fz),
        .orig_tx     (d_tx),
        .orig_tz     (d_tz),
        .base_tx     (d_btx),
        .base_tz     (d_btz),
        .mag_dx      (d_mdx),
        .mag_dz      (d_mdz),
        .mag_dy      (d_mdy),
        .mag_nf      (d_mnf),
        .mag_nt      (d_mnt),
        .neg_fx      (d_nfx),
        .neg_fz      (d_nfz),
        .neg_tx      (d_ntx),
        .neg_tz      (d_ntz)
    );

    // four lanes; altitude is exact at the boundary and needs none
    sasc_lane #(.COORD_BITS(C)) u_lane_fx (
        .clk(clk), .en(adv), .base(d_fx), .mag_a(d_mdx), .mag_b(d_mnf),
        .mag_c(d_mdy), .neg(d_nfx), .result(l_fx)
    );

    sasc_lane #(.COORD_BITS(C)) u_lane_fz (
        .clk(clk), .en(adv), .base(d_fz), .mag_a(d_mdz), .mag_b(d_mnf),
        .mag_c(d_mdy), .neg(d_nfz), .result(l_fz)
    );

    sasc_lane #(.COORD_BITS(C)) u_lane_tx (
        .clk(clk), .en(adv), .base(d_btx), .mag_a(d_mdx), .mag_b(d_mnt),
        .mag_c(d_mdy), .neg(d_ntx), .result(l_tx)
    );

    sasc_lane #(.COORD_BITS(C)) u_lane_tz (
        .clk(clk), .en(adv), .base(d_btz), .mag_a(d_mdz), .mag_b(d_mnt),
        .mag_c(d_mdy), .neg(d_ntz), .result(l_tz)
    );

    // valid bits, matched to decode plus lane depth
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_vld_reg <= 1'b0;
            for (int i = 0; i < L; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            dec_vld_reg <= in_valid;
            vld_reg[0]  <= dec_vld_reg;
            for (int i = 1; i < L; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    // sideband delay line alongside the lanes
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            flg_reg[0] <= d_flags;
            cfy_reg[0] <= d_cfy;
            cty_reg[0] <= d_cty;
            fx_reg[0]  <= d_fx;
            fz_reg[0]  <= d_fz;
            tx_reg[0]  <= d_tx;
            tz_reg[0]  <= d_tz;
            for (int i = 1; i < L; i++)
            begin
                flg_reg[i] <= flg_reg[i-1];
                cfy_reg[i] <= cfy_reg[i-1];
                cty_reg[i] <= cty_reg[i-1];
                fx_reg[i]  <= fx_reg[i-1];
                fz_reg[i]  <= fz_reg[i-1];
                tx_reg[i]  <= tx_reg[i-1];
                tz_reg[i]  <= tz_reg[i-1];
            end
        end
    end

    // unmoved points pass through untouched
    assign out_valid    = vld_reg[L-1];
    assign touches_slab = flg_reg[L-1].hit;
    assign clip_from_x  = flg_reg[L-1].mv_from ? l_fx : fx_reg[L-1];
    assign clip_from_y  = cfy_reg[L-1];
    assign clip_from_z  = flg_reg[L-1].mv_from ? l_fz : fz_reg[L-1];
    assign clip_to_x    = flg_reg[L-1].mv_to ? l_tx : tx_reg[L-1];
    assign clip_to_y    = cty_reg[L-1];
    assign clip_to_z    = flg_reg[L-1].mv_to ? l_tz : tz_reg[L-1];

endmodule
